// ===== hdl/zhfp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zhfp_pkg
// Shared constants, tags and types of the directory header field parser.
// ----------------------------------------------------------------------------
package zhfp_pkg;

    localparam logic [2:0] PH_FIXED   = 3'd0;
    localparam logic [2:0] PH_NAME    = 3'd1;
    localparam logic [2:0] PH_XHDR    = 3'd2;
    localparam logic [2:0] PH_XDATA   = 3'd3;
    localparam logic [2:0] PH_XSKIP   = 3'd4;
    localparam logic [2:0] PH_COMMENT = 3'd5;

    localparam logic [3:0] SD_IDLE    = 4'd0;
    localparam logic [3:0] SD_UT      = 4'd1;
    localparam logic [3:0] SD_UX_VER  = 4'd2;
    localparam logic [3:0] SD_UX_USZ  = 4'd3;
    localparam logic [3:0] SD_UX_UID  = 4'd4;
    localparam logic [3:0] SD_UX_GSZ  = 4'd5;
    localparam logic [3:0] SD_UX_GID  = 4'd6;
    localparam logic [3:0] SD_NT_RSV  = 4'd7;
    localparam logic [3:0] SD_NT_HDR  = 4'd8;
    localparam logic [3:0] SD_NT_DATA = 4'd9;

    localparam logic [5:0] T_ERR     = 6'd0;
    localparam logic [5:0] T_VMADE   = 6'd1;
    localparam logic [5:0] T_VNEED   = 6'd2;
    localparam logic [5:0] T_FLAGS   = 6'd3;
    localparam logic [5:0] T_UTF8    = 6'd4;
    localparam logic [5:0] T_METHOD  = 6'd5;
    localparam logic [5:0] T_HOUR    = 6'd6;
    localparam logic [5:0] T_MINUTE  = 6'd7;
    localparam logic [5:0] T_SECOND  = 6'd8;
    localparam logic [5:0] T_YEAR    = 6'd9;
    localparam logic [5:0] T_MONTH   = 6'd10;
    localparam logic [5:0] T_DAY     = 6'd11;
    localparam logic [5:0] T_CRC     = 6'd12;
    localparam logic [5:0] T_CSIZE   = 6'd13;
    localparam logic [5:0] T_USIZE   = 6'd14;
    localparam logic [5:0] T_NAMELEN = 6'd15;
    localparam logic [5:0] T_XLEN    = 6'd16;
    localparam logic [5:0] T_CMTLEN  = 6'd17;
    localparam logic [5:0] T_DISK    = 6'd18;
    localparam logic [5:0] T_IATTR   = 6'd19;
    localparam logic [5:0] T_EATTR   = 6'd20;
    localparam logic [5:0] T_OFFSET  = 6'd21;
    localparam logic [5:0] T_NAMEB   = 6'd22;
    localparam logic [5:0] T_CMTB    = 6'd23;
    localparam logic [5:0] T_XID     = 6'd24;
    localparam logic [5:0] T_XSIZE   = 6'd25;
    localparam logic [5:0] T_UTIME   = 6'd26;
    localparam logic [5:0] T_UXVER   = 6'd29;
    localparam logic [5:0] T_UID     = 6'd30;
    localparam logic [5:0] T_GID     = 6'd31;
    localparam logic [5:0] T_NTTAG   = 6'd32;
    localparam logic [5:0] T_NTSIZE  = 6'd33;
    localparam logic [5:0] T_NTTIME  = 6'd34;
    localparam logic [5:0] T_END     = 6'd37;

    localparam logic [1:0] REG_KIND  = 2'd0;
    localparam logic [1:0] REG_LIMIT = 2'd1;
    localparam logic [1:0] REG_DIR   = 2'd2;

    localparam logic [31:0] SIG_CENTRAL = 32'h02014b50;
    localparam logic [31:0] SIG_LOCAL   = 32'h04034b50;
    localparam logic [15:0] ID_UTIME    = 16'h5455;
    localparam logic [15:0] ID_UNIX     = 16'h7875;
    localparam logic [15:0] ID_NTFS     = 16'h000a;
    localparam logic [15:0] NT_TIMES    = 16'h0001;
    localparam logic [15:0] YEAR_BASE   = 16'd1980;

    localparam int MAX_RES = 4;

    typedef struct packed {
        logic [5:0]  tag;
        logic [63:0] value;
    } t_res;

    typedef struct packed {
        logic [2:0]  count;
        logic [15:0] entry;
        t_res [MAX_RES-1:0] res;
    } t_bundle;

endpackage
`default_nettype wire

// ===== hdl/zip_header_field_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zip_header_field_parser
// Parses directory or local header bytes into tagged fields.
//
// Channel | Dir | Handshake          | Payload
// input   | in  | i_valid / o_ready  | i_data_byte
// result  | out | o_valid / i_ready  | o_field_tag, o_field_value,
//         |     |                    | o_entry_number, o_last_of_run
// config  | in  | i_cfg_we           | i_cfg_index, i_cfg_data
//
// One byte per cycle, when not stalled, is taken into an input register and
// parsed, once the result buffer is free, into up to four results held in it;
// results leave that buffer one per cycle while i_ready is high.
// Synchronous active-low reset. A byte is taken whenever the input register or
// the buffer is empty or the buffer drains this cycle; the register holds under stall.
// ----------------------------------------------------------------------------
module zip_header_field_parser
    import zhfp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [5:0]       o_field_tag,
    output logic [63:0]      o_field_value,
    output logic [15:0]      o_entry_number,
    output logic             o_last_of_run,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    logic        r_kind;
    logic [15:0] r_limit;
    logic [31:0] r_dir;
    logic        r_iv;
    logic [7:0]  r_ib;
    t_bundle     bundle;
    logic        ob_free;
    logic        step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= 1'b1; r_limit <= '0; r_dir <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_KIND:  r_kind  <= i_cfg_data[0];
                REG_LIMIT: r_limit <= i_cfg_data[15:0];
                REG_DIR:   r_dir   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign step    = r_iv && ob_free;
    assign o_ready = !r_iv || ob_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (o_ready) begin
            r_iv <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ib <= i_data_byte;
        end
    end

    zhfp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_ib),
        .i_kind   (r_kind),
        .i_limit  (r_limit),
        .i_dir    (r_dir),
        .o_bundle (bundle)
    );

    zhfp_outbuf u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (step),
        .i_bundle       (bundle),
        .o_free         (ob_free),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_field_tag    (o_field_tag),
        .o_field_value  (o_field_value),
        .o_entry_number (o_entry_number),
        .o_last_of_run  (o_last_of_run)
    );

endmodule
`default_nettype wire

// ===== hdl/zhfp_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zhfp_core
// Parser state and per-byte update; yields up to four results per byte.
// ----------------------------------------------------------------------------
module zhfp_core
    import zhfp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_step,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_kind,
    input  wire logic [15:0] i_limit,
    input  wire logic [31:0] i_dir,
    output t_bundle          o_bundle
);

    logic [5:0]  r_hidx, n_hidx;
    logic [2:0]  r_phase, n_phase;
    logic [63:0] r_acc, n_acc;
    logic [15:0] r_ecnt, n_ecnt;
    logic [31:0] r_scnt, n_scnt;
    logic [15:0] r_nlen, n_nlen, r_xlen, n_xlen, r_clen, n_clen;
    logic [15:0] r_sleft, n_sleft, r_ileft, n_ileft, r_isize, n_isize;
    logic [3:0]  r_sd, n_sd;
    logic        r_halt, n_halt, r_kind, n_kind;
    logic [15:0] r_scount, n_scount, r_sidx, n_sidx;
    logic [63:0] r_sval, n_sval;
    logic [2:0]  r_utm, n_utm;
    logic        r_ntd, n_ntd;

    t_bundle b;
    logic [63:0] sh;
    logic [15:0] v16;
    logic [31:0] v32;
    logic [5:0]  slot;
    logic        fin;
    logic        nsec;
    logic [2:0]  from;
    logic [15:0] prior, off, k, idx1, sz;
    logic [1:0]  j, n;
    logic [63:0] sv;
    logic [15:0] ntag, nsize;
    logic [2:0]  bit3;

    function automatic t_bundle add(input t_bundle bb, input logic [5:0] t,
                                    input logic [63:0] v);
        t_bundle r;
        r = bb;
        if (r.count < 3'(MAX_RES)) begin
            r.res[r.count[1:0]].tag   = t;
            r.res[r.count[1:0]].value = v;
            r.count = r.count + 3'd1;
        end
        return r;
    endfunction

    always_comb begin
        n_hidx = r_hidx; n_phase = r_phase; n_acc = r_acc; n_ecnt = r_ecnt;
        n_scnt = r_scnt; n_nlen = r_nlen; n_xlen = r_xlen; n_clen = r_clen;
        n_sleft = r_sleft; n_ileft = r_ileft; n_isize = r_isize; n_sd = r_sd;
        n_halt = r_halt; n_kind = r_kind; n_scount = r_scount; n_sidx = r_sidx;
        n_sval = r_sval; n_utm = r_utm; n_ntd = r_ntd;
        b = '0;
        sh = '0; v16 = '0; v32 = '0; slot = '0; fin = 1'b0; nsec = 1'b0;
        from = PH_FIXED; prior = '0; off = '0; k = '0; idx1 = '0; sz = '0;
        j = '0; n = '0; sv = '0; ntag = '0; nsize = '0; bit3 = '0;
        if (i_step && !r_halt) begin
            if (r_phase == PH_FIXED && r_hidx == 6'd0 &&
                (r_ecnt >= i_limit || r_scnt >= i_dir)) begin
                n_halt = 1'b1;
            end else begin
                if (r_phase == PH_FIXED && r_hidx == 6'd0) begin
                    n_kind = i_kind;
                end
                if (r_scnt != 32'hffffffff) begin
                    n_scnt = r_scnt + 32'd1;
                end
                case (r_phase)
                    PH_FIXED: begin
                        slot = (n_kind || r_hidx < 6'd4) ? r_hidx : r_hidx + 6'd2;
                        sh = {i_byte, r_acc[63:8]};
                        n_acc = sh;
                        v16 = sh[63:48];
                        v32 = sh[63:32];
                        n_hidx = r_hidx + 6'd1;
                        case (slot)
                            6'd3: begin
                                if (v32 != (n_kind ? SIG_CENTRAL : SIG_LOCAL)) begin
                                    b = add(b, T_ERR, {32'd0, v32});
                                    n_halt = 1'b1;
                                end
                            end
                            6'd5:  b = add(b, T_VMADE, {48'd0, v16});
                            6'd7:  b = add(b, T_VNEED, {48'd0, v16});
                            6'd9: begin
                                b = add(b, T_FLAGS, {48'd0, v16});
                                b = add(b, T_UTF8, {63'd0, v16[11]});
                            end
                            6'd11: b = add(b, T_METHOD, {48'd0, v16});
                            6'd13: begin
                                b = add(b, T_HOUR, {59'd0, v16[15:11]});
                                b = add(b, T_MINUTE, {58'd0, v16[10:5]});
                                b = add(b, T_SECOND, {58'd0, v16[4:0], 1'b0});
                            end
                            6'd15: begin
                                b = add(b, T_YEAR, {48'd0, YEAR_BASE + {9'd0, v16[15:9]}});
                                b = add(b, T_MONTH, {60'd0, v16[8:5]});
                                b = add(b, T_DAY, {59'd0, v16[4:0]});
                            end
                            6'd19: b = add(b, T_CRC, {32'd0, v32});
                            6'd23: b = add(b, T_CSIZE, {32'd0, v32});
                            6'd27: b = add(b, T_USIZE, {32'd0, v32});
                            6'd29: begin
                                n_nlen = v16; b = add(b, T_NAMELEN, {48'd0, v16});
                            end
                            6'd31: begin
                                n_xlen = v16; b = add(b, T_XLEN, {48'd0, v16});
                            end
                            6'd33: begin
                                n_clen = v16; b = add(b, T_CMTLEN, {48'd0, v16});
                            end
                            6'd35: b = add(b, T_DISK, {48'd0, v16});
                            6'd37: b = add(b, T_IATTR, {48'd0, v16});
                            6'd41: b = add(b, T_EATTR, {32'd0, v32});
                            6'd45: b = add(b, T_OFFSET, {32'd0, v32});
                            default: ;
                        endcase
                        if (!n_halt && slot == (n_kind ? 6'd45 : 6'd31)) begin
                            if (!n_kind) begin
                                n_clen = '0;
                            end
                            nsec = 1'b1;
                            from = PH_FIXED;
                        end
                    end
                    PH_NAME, PH_COMMENT: begin
                        b = add(b, (r_phase == PH_NAME) ? T_NAMEB : T_CMTB,
                                {56'd0, i_byte});
                        n_sleft = r_sleft - 16'd1;
                        if (n_sleft == 16'd0) begin
                            nsec = 1'b1;
                            from = r_phase;
                        end
                    end
                    default: begin
                        prior = r_sleft;
                        n_sleft = prior - 16'd1;
                        if (r_phase == PH_XHDR) begin
                            if (r_hidx == 6'd0 && prior <= 16'd4) begin
                                n_phase = PH_XSKIP;
                            end else begin
                                sh = {i_byte, r_acc[63:8]};
                                n_acc = sh;
                                n_hidx = r_hidx + 6'd1;
                                if (n_hidx >= 6'd4) begin
                                    sz = sh[63:48];
                                    n_isize = sz;
                                    b = add(b, T_XID, {48'd0, sh[47:32]});
                                    b = add(b, T_XSIZE, {48'd0, sz});
                                    n_hidx = '0;
                                    if (sz > n_sleft) begin
                                        n_phase = PH_XSKIP;
                                    end else begin
                                        n_ileft = sz;
                                        if (sh[47:32] == ID_UTIME) n_sd = SD_UT;
                                        else if (sh[47:32] == ID_UNIX) n_sd = SD_UX_VER;
                                        else if (sh[47:32] == ID_NTFS) n_sd = SD_NT_RSV;
                                        else n_sd = SD_IDLE;
                                        if (sz != 16'd0) n_phase = PH_XDATA;
                                    end
                                end
                            end
                        end else if (r_phase == PH_XDATA) begin
                            off = r_isize - r_ileft;
                            n_ileft = r_ileft - 16'd1;
                            case (r_sd)
                                SD_UT: begin
                                    if (off == 16'd0) begin
                                        n_utm = r_kind ? {2'b00, r_isize >= 16'd5}
                                                       : i_byte[2:0];
                                    end else begin
                                        k = (off - 16'd1) >> 2;
                                        j = 2'(off - 16'd1);
                                        sv = (j == 2'd0) ? 64'd0 : r_sval;
                                        sv = sv | ({56'd0, i_byte} << {j, 3'b000});
                                        n_sval = sv;
                                        if (j == 2'd3) begin
                                            n = '0;
                                            for (int i = 0; i < 3; i++) begin
                                                if (r_utm[i]) begin
                                                    if ({14'd0, n} == k) begin
                                                        bit3 = 3'(i);
                                                        b = add(b, T_UTIME + {3'd0, bit3},
                                                                sv);
                                                    end
                                                    n = n + 2'd1;
                                                end
                                            end
                                        end
                                    end
                                end
                                SD_UX_VER: begin
                                    b = add(b, T_UXVER, {56'd0, i_byte});
                                    n_sd = (i_byte == 8'd1) ? SD_UX_USZ : SD_IDLE;
                                end
                                SD_UX_USZ, SD_UX_GSZ: begin
                                    if ({8'd0, i_byte} > n_ileft) begin
                                        n_sd = SD_IDLE;
                                    end else begin
                                        n_scount = {8'd0, i_byte};
                                        n_sidx = '0;
                                        n_sval = '0;
                                        if (i_byte != 8'd0) begin
                                            n_sd = (r_sd == SD_UX_USZ) ? SD_UX_UID
                                                                       : SD_UX_GID;
                                        end else if (r_sd == SD_UX_USZ) begin
                                            n_acc = '0;
                                            n_sd = SD_UX_GSZ;
                                        end else begin
                                            b = add(b, T_UID, r_acc);
                                            b = add(b, T_GID, 64'd0);
                                            n_sd = SD_IDLE;
                                        end
                                    end
                                end
                                SD_UX_UID, SD_UX_GID: begin
                                    sv = r_sval;
                                    if (r_sidx < 16'd8) begin
                                        sv = sv | ({56'd0, i_byte} << {r_sidx[2:0], 3'b000});
                                    end
                                    n_sval = sv;
                                    idx1 = r_sidx + 16'd1;
                                    n_sidx = idx1;
                                    if (idx1 >= r_scount) begin
                                        if (r_sd == SD_UX_UID) begin
                                            n_acc = sv;
                                            n_sd = SD_UX_GSZ;
                                        end else begin
                                            b = add(b, T_UID, r_acc);
                                            b = add(b, T_GID, sv);
                                            n_sd = SD_IDLE;
                                        end
                                    end
                                end
                                SD_NT_RSV: begin
                                    if (off >= 16'd3) begin
                                        n_sd = SD_NT_HDR;
                                        n_sidx = '0;
                                        n_sval = '0;
                                    end
                                end
                                SD_NT_HDR: begin
                                    sv = r_sval | ({56'd0, i_byte} << {r_sidx[1:0], 3'b000});
                                    n_sval = sv;
                                    idx1 = r_sidx + 16'd1;
                                    n_sidx = idx1;
                                    if (idx1 >= 16'd4) begin
                                        ntag = sv[15:0];
                                        nsize = sv[31:16];
                                        b = add(b, T_NTTAG, {48'd0, ntag});
                                        b = add(b, T_NTSIZE, {48'd0, nsize});
                                        n_sidx = '0;
                                        n_sval = '0;
                                        if (nsize > n_ileft) begin
                                            n_sd = SD_IDLE;
                                        end else if (nsize != 16'd0) begin
                                            n_ntd = (ntag == NT_TIMES) && (nsize >= 16'd24);
                                            n_scount = nsize;
                                            n_sd = SD_NT_DATA;
                                        end
                                    end
                                end
                                SD_NT_DATA: begin
                                    if (r_ntd && r_sidx < 16'd24) begin
                                        sv = (r_sidx[2:0] == 3'd0) ? 64'd0 : r_sval;
                                        sv = sv | ({56'd0, i_byte} << {r_sidx[2:0], 3'b000});
                                        n_sval = sv;
                                        if (r_sidx[2:0] == 3'd7) begin
                                            b = add(b, T_NTTIME + {4'd0, r_sidx[4:3]}, sv);
                                        end
                                    end
                                    n_sidx = r_sidx + 16'd1;
                                    n_scount = r_scount - 16'd1;
                                    if (n_scount == 16'd0) begin
                                        n_sd = SD_NT_HDR;
                                        n_sidx = '0;
                                        n_sval = '0;
                                    end
                                end
                                default: ;
                            endcase
                            if (n_ileft == 16'd0) begin
                                n_phase = PH_XHDR;
                                n_hidx = '0;
                            end
                        end
                        if (n_sleft == 16'd0) begin
                            nsec = 1'b1;
                            from = PH_XHDR;
                        end
                    end
                endcase
                if (nsec) begin
                    if (from == PH_FIXED && n_nlen != 16'd0) begin
                        n_phase = PH_NAME;
                        n_sleft = n_nlen;
                    end else if (from <= PH_NAME && n_xlen != 16'd0) begin
                        n_phase = PH_XHDR;
                        n_sleft = n_xlen;
                        n_hidx = '0;
                    end else if (from <= PH_XSKIP && n_clen != 16'd0) begin
                        n_phase = PH_COMMENT;
                        n_sleft = n_clen;
                    end else begin
                        fin = 1'b1;
                    end
                end
                b.entry = r_ecnt;
                if (fin) begin
                    b = add(b, T_END, {32'd0, 32'(r_kind ? 16'd46 : 16'd30)
                        + 32'(n_nlen) + 32'(n_xlen) + 32'(n_clen)});
                    n_ecnt = r_ecnt + 16'd1;
                    n_phase = PH_FIXED;
                    n_hidx = '0;
                end
            end
        end
        o_bundle = b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hidx <= '0; r_phase <= PH_FIXED; r_acc <= '0; r_ecnt <= '0;
            r_scnt <= '0; r_nlen <= '0; r_xlen <= '0; r_clen <= '0;
            r_sleft <= '0; r_ileft <= '0; r_isize <= '0; r_sd <= SD_IDLE;
            r_halt <= 1'b0; r_kind <= 1'b1; r_scount <= '0; r_sidx <= '0;
            r_sval <= '0; r_utm <= '0; r_ntd <= 1'b0;
        end else begin
            r_hidx <= n_hidx; r_phase <= n_phase; r_acc <= n_acc; r_ecnt <= n_ecnt;
            r_scnt <= n_scnt; r_nlen <= n_nlen; r_xlen <= n_xlen; r_clen <= n_clen;
            r_sleft <= n_sleft; r_ileft <= n_ileft; r_isize <= n_isize; r_sd <= n_sd;
            r_halt <= n_halt; r_kind <= n_kind; r_scount <= n_scount; r_sidx <= n_sidx;
            r_sval <= n_sval; r_utm <= n_utm; r_ntd <= n_ntd;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/zhfp_outbuf.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zhfp_outbuf
// Result buffer: holds one byte's results and sends them one per transfer.
// ----------------------------------------------------------------------------
module zhfp_outbuf
    import zhfp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_bundle i_bundle,
    output logic         o_free,
    output logic         o_valid,
    input  wire logic    i_ready,
    output logic [5:0]   o_field_tag,
    output logic [63:0]  o_field_value,
    output logic [15:0]  o_entry_number,
    output logic         o_last_of_run
);

    t_bundle    r_b;
    logic [2:0] r_pos, n_pos;
    logic       last;

    assign o_valid        = (r_pos < r_b.count);
    assign last           = (r_pos + 3'd1 == r_b.count);
    assign o_free         = !o_valid || (i_ready && last);
    assign o_field_tag    = r_b.res[r_pos[1:0]].tag;
    assign o_field_value  = r_b.res[r_pos[1:0]].value;
    assign o_entry_number = r_b.entry;
    assign o_last_of_run  = last;

    always_comb begin
        n_pos = r_pos;
        if (o_valid && i_ready) begin
            n_pos = r_pos + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b.count <= '0;
            r_pos     <= '0;
        end else if (i_load) begin
            r_b   <= i_bundle;
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/zhfp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zhfp_checker
// Port-level checks of the parser, bound to the top level.
// ----------------------------------------------------------------------------
module zhfp_checker
    import zhfp_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [5:0]  o_field_tag,
    input wire logic [63:0] o_field_value,
    input wire logic [15:0] o_entry_number,
    input wire logic        o_last_of_run
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_field_tag)
            && $stable(o_field_value))
        else $error("result changed under stall");

    a_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_field_tag <= T_END)
        else $error("tag out of range");

    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_field_tag == T_END |-> o_last_of_run)
        else $error("entry end not last of run");

    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_field_tag == T_ERR |=> !o_valid)
        else $error("output after signature error");

    a_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_of_run |=> $stable(o_entry_number))
        else $error("entry number changed within a run");

endmodule

bind zip_header_field_parser zhfp_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_field_tag    (o_field_tag),
    .o_field_value  (o_field_value),
    .o_entry_number (o_entry_number),
    .o_last_of_run  (o_last_of_run)
);
`default_nettype wire

// ===== dv/tb_zip_header_field_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_zip_header_field_parser
// Feeds generated central and local header records, with name, extra items
// of the timestamp, uid/gid, filetime and other kinds, and, for central ones,
// comment, through the parser under random stalls on both channels. A scoreboard
// predicts every tagged field and checks each result transfer in order. The run
// ends in one of the halting cases: bad signature, entry limit or byte limit.
// ----------------------------------------------------------------------------
module tb_zip_header_field_parser;
    import zhfp_pkg::*;

    typedef struct {
        logic [5:0]  tag;
        logic [63:0] value;
        logic [15:0] entry;
        logic        last;
    } t_field;

    class field_scoreboard;
        t_field      pending[$];
        bit          kind_reg;
        bit [15:0]   limit_reg;
        bit [31:0]   dir_reg;
        bit [5:0]    hdr_idx;
        bit [2:0]    phase;
        bit [63:0]   acc;
        bit [15:0]   entry_count;
        bit [31:0]   byte_count;
        bit [15:0]   name_len, xlen, cmt_len, sec_left, item_id, item_left;
        bit [3:0]    sub_state;
        bit          halted;
        bit          rec_kind;
        bit [31:0]   item_size, sub_count, sub_index, ut_mask;
        bit [63:0]   sub_value;
        bit          nt_decode;
        bit [5:0]    rt[4];
        bit [63:0]   rv[4];
        int          rn;

        function new();
            kind_reg = 1; limit_reg = 0; dir_reg = 0;
            hdr_idx = 0; phase = PH_FIXED; acc = 0; entry_count = 0;
            byte_count = 0; name_len = 0; xlen = 0; cmt_len = 0;
            sec_left = 0; item_id = 0; item_left = 0; sub_state = SD_IDLE;
            halted = 0; rec_kind = 1; item_size = 0; sub_count = 0;
            sub_index = 0; ut_mask = 0; sub_value = 0; nt_decode = 0;
        endfunction

        function void write_reg(bit [1:0] idx, bit [31:0] d);
            if (idx == REG_KIND) kind_reg = d[0];
            else if (idx == REG_LIMIT) limit_reg = d[15:0];
            else if (idx == REG_DIR) dir_reg = d;
        endfunction

        function void emit(bit [5:0] t, bit [63:0] v);
            if (rn < 4) begin
                rt[rn] = t; rv[rn] = v; rn++;
            end
        endfunction

        function void finish_entry();
            emit(T_END, (rec_kind ? 46 : 30) + name_len + xlen + cmt_len);
            entry_count++;
            phase = PH_FIXED;
            hdr_idx = 0;
        endfunction

        function void next_section(bit [2:0] from);
            if (from == PH_FIXED && name_len != 0) begin
                phase = PH_NAME; sec_left = name_len;
            end else if (from <= PH_NAME && xlen != 0) begin
                phase = PH_XHDR; sec_left = xlen; hdr_idx = 0;
            end else if (from <= PH_XSKIP && cmt_len != 0) begin
                phase = PH_COMMENT; sec_left = cmt_len;
            end else begin
                finish_entry();
            end
        endfunction

        function void fixed_byte(bit [7:0] by);
            int unsigned slot;
            bit [15:0] v16;
            bit [31:0] v32;
            slot = (rec_kind || hdr_idx < 4) ? hdr_idx : hdr_idx + 2;
            acc = (acc >> 8) | ({56'd0, by} << 56);
            v16 = acc[63:48];
            v32 = acc[63:32];
            hdr_idx++;
            case (slot)
                3: if (v32 != (rec_kind ? SIG_CENTRAL : SIG_LOCAL)) begin
                    emit(T_ERR, v32);
                    halted = 1;
                    return;
                end
                5: emit(T_VMADE, v16);
                7: emit(T_VNEED, v16);
                9: begin
                    emit(T_FLAGS, v16); emit(T_UTF8, v16[11]);
                end
                11: emit(T_METHOD, v16);
                13: begin
                    emit(T_HOUR, v16[15:11]); emit(T_MINUTE, v16[10:5]);
                    emit(T_SECOND, 2 * v16[4:0]);
                end
                15: begin
                    emit(T_YEAR, YEAR_BASE + v16[15:9]); emit(T_MONTH, v16[8:5]);
                    emit(T_DAY, v16[4:0]);
                end
                19: emit(T_CRC, v32);
                23: emit(T_CSIZE, v32);
                27: emit(T_USIZE, v32);
                29: begin name_len = v16; emit(T_NAMELEN, v16); end
                31: begin xlen = v16; emit(T_XLEN, v16); end
                33: begin cmt_len = v16; emit(T_CMTLEN, v16); end
                35: emit(T_DISK, v16);
                37: emit(T_IATTR, v16);
                41: emit(T_EATTR, v32);
                45: emit(T_OFFSET, v32);
                default: ;
            endcase
            if (slot == (rec_kind ? 45 : 31)) begin
                if (!rec_kind) cmt_len = 0;
                next_section(PH_FIXED);
            end
        endfunction

        function void item_byte(bit [7:0] by, bit [31:0] off);
            bit [31:0] j, k, n;
            bit [15:0] atag, asize;
            case (sub_state)
                SD_UT: begin
                    if (off == 0) begin
                        ut_mask = rec_kind ? (item_size >= 5 ? 1 : 0) : by[2:0];
                    end else begin
                        k = (off - 1) >> 2;
                        j = (off - 1) & 3;
                        if (j == 0) sub_value = 0;
                        sub_value |= {56'd0, by} << (8 * j);
                        if (j == 3) begin
                            n = 0;
                            for (int b = 0; b < 3; b++) begin
                                if (ut_mask[b]) begin
                                    if (n == k) emit(T_UTIME + 6'(b), sub_value);
                                    n++;
                                end
                            end
                        end
                    end
                end
                SD_UX_VER: begin
                    emit(T_UXVER, by);
                    sub_state = (by == 1) ? SD_UX_USZ : SD_IDLE;
                end
                SD_UX_USZ, SD_UX_GSZ: begin
                    if (by > item_left) begin
                        sub_state = SD_IDLE;
                    end else begin
                        sub_count = by; sub_index = 0; sub_value = 0;
                        if (by != 0) begin
                            sub_state = (sub_state == SD_UX_USZ) ? SD_UX_UID : SD_UX_GID;
                        end else if (sub_state == SD_UX_USZ) begin
                            acc = 0; sub_state = SD_UX_GSZ;
                        end else begin
                            emit(T_UID, acc); emit(T_GID, 0); sub_state = SD_IDLE;
                        end
                    end
                end
                SD_UX_UID, SD_UX_GID: begin
                    if (sub_index < 8) sub_value |= {56'd0, by} << (8 * sub_index);
                    sub_index++;
                    if (sub_index >= sub_count) begin
                        if (sub_state == SD_UX_UID) begin
                            acc = sub_value; sub_state = SD_UX_GSZ;
                        end else begin
                            emit(T_UID, acc); emit(T_GID, sub_value); sub_state = SD_IDLE;
                        end
                    end
                end
                SD_NT_RSV: if (off >= 3) begin
                    sub_state = SD_NT_HDR; sub_index = 0; sub_value = 0;
                end
                SD_NT_HDR: begin
                    sub_value |= {56'd0, by} << (8 * (sub_index & 3));
                    sub_index++;
                    if (sub_index >= 4) begin
                        atag = sub_value[15:0];
                        asize = sub_value[31:16];
                        emit(T_NTTAG, atag); emit(T_NTSIZE, asize);
                        sub_index = 0; sub_value = 0;
                        if (asize > item_left) begin
                            sub_state = SD_IDLE;
                        end else if (asize != 0) begin
                            nt_decode = (atag == NT_TIMES && asize >= 24);
                            sub_count = asize;
                            sub_state = SD_NT_DATA;
                        end
                    end
                end
                SD_NT_DATA: begin
                    if (nt_decode && sub_index < 24) begin
                        j = sub_index & 7;
                        if (j == 0) sub_value = 0;
                        sub_value |= {56'd0, by} << (8 * j);
                        if (j == 7) emit(T_NTTIME + 6'(sub_index >> 3), sub_value);
                    end
                    sub_index++;
                    sub_count--;
                    if (sub_count == 0) begin
                        sub_state = SD_NT_HDR; sub_index = 0; sub_value = 0;
                    end
                end
                default: ;
            endcase
        endfunction

        function void extra_byte(bit [7:0] by);
            bit [15:0] prior;
            bit [31:0] off;
            prior = sec_left;
            sec_left = prior - 16'd1;
            if (phase == PH_XHDR) begin
                if (hdr_idx == 0 && prior <= 4) begin
                    phase = PH_XSKIP;
                end else begin
                    acc = (acc >> 8) | ({56'd0, by} << 56);
                    hdr_idx++;
                    if (hdr_idx >= 4) begin
                        item_id = acc[47:32];
                        item_size = acc[63:48];
                        emit(T_XID, item_id); emit(T_XSIZE, item_size);
                        hdr_idx = 0;
                        if (item_size > sec_left) begin
                            phase = PH_XSKIP;
                        end else begin
                            item_left = item_size[15:0];
                            if (item_id == ID_UTIME) sub_state = SD_UT;
                            else if (item_id == ID_UNIX) sub_state = SD_UX_VER;
                            else if (item_id == ID_NTFS) sub_state = SD_NT_RSV;
                            else sub_state = SD_IDLE;
                            if (item_size != 0) phase = PH_XDATA;
                        end
                    end
                end
            end else if (phase == PH_XDATA) begin
                off = item_size - item_left;
                item_left--;
                item_byte(by, off);
                if (item_left == 0) begin
                    phase = PH_XHDR; hdr_idx = 0;
                end
            end
            if (sec_left == 0) next_section(PH_XHDR);
        endfunction

        function void note_byte(bit [7:0] by);
            t_field f;
            rn = 0;
            if (halted) return;
            if (phase == PH_FIXED && hdr_idx == 0) begin
                if (entry_count >= limit_reg || byte_count >= dir_reg) begin
                    halted = 1;
                    return;
                end
                rec_kind = kind_reg;
            end
            if (byte_count != 32'hffffffff) byte_count++;
            case (phase)
                PH_FIXED: fixed_byte(by);
                PH_NAME, PH_COMMENT: begin
                    emit(phase == PH_NAME ? T_NAMEB : T_CMTB, by);
                    sec_left--;
                    if (sec_left == 0) next_section(phase);
                end
                default: extra_byte(by);
            endcase
            for (int i = 0; i < rn; i++) begin
                f.tag = rt[i];
                f.value = rv[i];
                f.entry = (rt[rn-1] == T_END) ? entry_count - 16'd1 : entry_count;
                f.last = (i == rn - 1);
                pending.push_back(f);
            end
        endfunction

        function string check_field(t_field got);
            t_field want;
            string msg;
            if (pending.size() == 0)
                return $sformatf("unexpected transfer tag %0d value %h", got.tag, got.value);
            want = pending.pop_front();
            msg = "";
            if (got.tag != want.tag)
                msg = {msg, $sformatf(" tag %0d/%0d", got.tag, want.tag)};
            if (got.value != want.value)
                msg = {msg, $sformatf(" value %h/%h", got.value, want.value)};
            if (got.entry != want.entry)
                msg = {msg, $sformatf(" entry %0d/%0d", got.entry, want.entry)};
            if (got.last != want.last)
                msg = {msg, $sformatf(" last %0d/%0d", got.last, want.last)};
            if (msg != "") msg = {$sformatf("field tag %0d:", want.tag), msg};
            return msg;
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [7:0]  i_data_byte = 0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [5:0]  o_field_tag;
    logic [63:0] o_field_value;
    logic [15:0] o_entry_number;
    logic        o_last_of_run;
    logic        i_cfg_we = 0;
    logic [1:0]  i_cfg_index = 0;
    logic [31:0] i_cfg_data = 0;

    zip_header_field_parser DUT (.*);

    field_scoreboard sb = new();
    int   mismatches = 0;
    int   cycles = 0;
    bit   calm = 0;
    bit [7:0] rec[$];

    always #5 i_clk = ~i_clk;

    task automatic report(string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 200000) begin
            $display("tb_zip_header_field_parser: FAIL");
            $finish;
        end
    end

    always @(negedge i_clk)
        i_ready <= calm ? 1'b1 : ($urandom_range(99) >= 33);

    always @(posedge i_clk) begin
        string m;
        t_field got;
        if (i_rst_n && o_valid && i_ready) begin
            got.tag = o_field_tag;
            got.value = o_field_value;
            got.entry = o_entry_number;
            got.last = o_last_of_run;
            m = sb.check_field(got);
            if (m != "") report(m);
        end
    end

    task automatic send_byte(bit [7:0] b);
        if (!calm && $urandom_range(99) < 33) begin
            @(negedge i_clk);
            i_valid <= 0;
            repeat ($urandom_range(1)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1;
        i_data_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        sb.note_byte(b);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(bit [1:0] idx, bit [31:0] d);
        drain();
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        @(negedge i_clk);
        i_cfg_we <= 0;
        sb.write_reg(idx, d);
    endtask

    task automatic put16(ref bit [7:0] q[$], input bit [15:0] v);
        q.push_back(v[7:0]); q.push_back(v[15:8]);
    endtask

    task automatic put32(ref bit [7:0] q[$], input bit [31:0] v);
        put16(q, v[15:0]); put16(q, v[31:16]);
    endtask

    task automatic build_extra(ref bit [7:0] x[$]);
        int n, sel, sz;
        n = $urandom_range(3);
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(5);
            case (sel)
                0: begin
                    sz = $urandom_range(1, 13);
                    put16(x, ID_UTIME); put16(x, 16'(sz));
                    repeat (sz) x.push_back(8'($urandom));
                end
                1: begin
                    int us, gs;
                    us = ($urandom_range(3) == 0) ? $urandom_range(10) : 4;
                    gs = ($urandom_range(3) == 0) ? $urandom_range(10) : 4;
                    put16(x, ID_UNIX); put16(x, 16'(3 + us + gs));
                    x.push_back(($urandom_range(5) == 0) ? 8'($urandom) : 8'd1);
                    x.push_back(8'(us)); repeat (us) x.push_back(8'($urandom));
                    x.push_back(8'(gs)); repeat (gs) x.push_back(8'($urandom));
                end
                2: begin
                    sz = ($urandom_range(3) == 0) ? 8 : 0;
                    put16(x, ID_NTFS); put16(x, 16'(32 + sz));
                    put32(x, $urandom);
                    put16(x, NT_TIMES); put16(x, 16'd24);
                    repeat (24) x.push_back(8'($urandom));
                    if (sz != 0) begin
                        put16(x, 16'($urandom_range(2, 5)));
                        put16(x, 16'($urandom_range(4, 9)));
                    end
                end
                3: begin
                    sz = $urandom_range(6);
                    put16(x, 16'($urandom)); put16(x, 16'(sz));
                    repeat (sz) x.push_back(8'($urandom));
                end
                4: begin
                    put16(x, 16'($urandom)); put16(x, 16'($urandom_range(60, 16'hffff)));
                    repeat ($urandom_range(3)) x.push_back(8'($urandom));
                    return;
                end
                default: repeat ($urandom_range(1, 8)) x.push_back(8'($urandom));
            endcase
        end
        if ($urandom_range(2) == 0) repeat ($urandom_range(1, 4)) x.push_back(8'($urandom));
    endtask

    task automatic build_record(bit central);
        bit [7:0] nm[$], xt[$], cm[$];
        rec.delete();
        repeat ($urandom_range(3)) nm.push_back(8'($urandom));
        build_extra(xt);
        if (central) repeat ($urandom_range(3)) cm.push_back(8'($urandom));
        put32(rec, central ? SIG_CENTRAL : SIG_LOCAL);
        if (central) put16(rec, 16'($urandom));
        put16(rec, 16'($urandom));
        put16(rec, 16'($urandom));
        put16(rec, 16'($urandom));
        put16(rec, 16'($urandom));
        put16(rec, 16'($urandom));
        put32(rec, $urandom);
        put32(rec, $urandom);
        put32(rec, $urandom);
        put16(rec, 16'(nm.size()));
        put16(rec, 16'(xt.size()));
        if (central) begin
            put16(rec, 16'(cm.size()));
            put16(rec, 16'($urandom));
            put16(rec, 16'($urandom));
            put32(rec, $urandom);
            put32(rec, $urandom);
        end
        rec = {rec, nm, xt, cm};
    endtask

    task automatic send_record(bit central);
        build_record(central);
        foreach (rec[i]) send_byte(rec[i]);
    endtask

    initial begin
        int sent;
        int finale;
        bit kind;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        write_reg(REG_KIND, 1);
        write_reg(REG_LIMIT, 16'hffff);
        write_reg(REG_DIR, 32'hffffffff);
        sent = 0;
        send_record(1);
        sent += rec.size();
        write_reg(REG_KIND, 0);
        calm = 1;
        send_record(0);
        sent += rec.size();
        calm = 0;
        kind = 0;
        while (sent < 180) begin
            if ($urandom_range(3) == 0) begin
                kind = 1'($urandom);
                write_reg(REG_KIND, kind);
                write_reg(REG_DIR, sb.byte_count + $urandom_range(100000, 32'hfffffff0));
            end
            if ($urandom_range(4) == 0) drain();
            send_record(kind);
            sent += rec.size();
        end
        calm = 0;
        finale = $urandom_range(2);
        if (finale == 0) begin
            send_byte(8'h4f);
            repeat (3) send_byte(8'($urandom));
        end else if (finale == 1) begin
            write_reg(REG_LIMIT, sb.entry_count);
        end else begin
            write_reg(REG_DIR, sb.byte_count);
        end
        repeat (6) send_byte(8'($urandom));
        drain();
        if (mismatches == 0 && sb.pending.size() == 0) begin
            $display("tb_zip_header_field_parser: PASS");
        end else begin
            $display("tb_zip_header_field_parser: FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/zhfp_pkg.sv
hdl/zhfp_core.sv
hdl/zip_header_field_parser.sv
hdl/zhfp_outbuf.sv
hdl/zhfp_checker.sv
dv/tb_zip_header_field_parser.sv
